@@ design/tcp_flow_tracking_table_macros.svh @@
// assertion macros for the flow table checker
`ifndef TCP_FLOW_TRACKING_TABLE_MACROS_SVH
`define TCP_FLOW_TRACKING_TABLE_MACROS_SVH
// property that holds whenever reset is released
`define FT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked during reset as well
`define FT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/tft_pkg.sv @@
// shared types and codes of the flow tracking table
package tft_pkg;
    localparam logic [1:0] OP_PACKET   = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_TOUCH    = 2'd2;
    localparam logic [1:0] OP_SCAN     = 2'd3;

    localparam logic [3:0] ST_TRACKED   = 4'd0;
    localparam logic [3:0] ST_NEW       = 4'd1;
    localparam logic [3:0] ST_IGNORED   = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_COMPLETED = 4'd4;
    localparam logic [3:0] ST_NOT_FOUND = 4'd5;
    localparam logic [3:0] ST_TOUCHED   = 4'd6;
    localparam logic [3:0] ST_IDLE      = 4'd7;
    localparam logic [3:0] ST_SCAN_DONE = 4'd8;

    localparam logic [1:0] FS_PENDING_DATA = 2'd0;
    localparam logic [1:0] FS_ACTIVE_SYN   = 2'd1;
    localparam logic [1:0] FS_ACTIVE_DATA  = 2'd2;

    localparam logic [0:0] CFG_MAX_FLOWS   = 1'd0;
    localparam logic [0:0] CFG_GRACE_TICKS = 1'd1;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } t_key;

    // one queued command from front to back
    typedef struct packed {
        logic [1:0]  op;
        t_key        key;
        logic        is_syn;
        logic        has_data;
        logic [47:0] timestamp;
        logic [31:0] idle_timeout;
    } t_cmd;

    typedef struct packed {
        logic [3:0] status;
        t_key       key;
        logic [1:0] flow_state;
        logic       last;
    } t_res;
endpackage

@@ design/tft_front.sv @@
// input stage: captures beats and queues them as commands
module tft_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_op,
    input  logic [31:0]   i_src_addr,
    input  logic [31:0]   i_dst_addr,
    input  logic [15:0]   i_src_port,
    input  logic [15:0]   i_dst_port,
    input  logic [7:0]    i_protocol,
    input  logic          i_is_syn,
    input  logic [15:0]   i_payload_len,
    input  logic [47:0]   i_timestamp,
    input  logic [31:0]   i_idle_timeout,
    output logic          o_cmd_valid,
    output tft_pkg::t_cmd o_cmd,
    input  logic          i_cmd_take
);
    // two-entry queue
    tft_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    tft_pkg::t_cmd cmd_in;

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // classify the beat into a command
    always_comb begin
        cmd_in.op           = i_op;
        cmd_in.key.src_addr = i_src_addr;
        cmd_in.key.dst_addr = i_dst_addr;
        cmd_in.key.src_port = i_src_port;
        cmd_in.key.dst_port = i_dst_port;
        cmd_in.key.protocol = i_protocol;
        cmd_in.is_syn       = i_is_syn;
        cmd_in.has_data     = (i_payload_len != 16'd0);
        cmd_in.timestamp    = i_timestamp;
        cmd_in.idle_timeout = i_idle_timeout;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_take};
        end
    end
endmodule

@@ design/tft_back.sv @@
// flow table and command execution
module tft_back #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    input  logic          i_cmd_valid,
    input  tft_pkg::t_cmd i_cmd,
    output logic          o_cmd_take,
    output logic          o_res_valid,
    output tft_pkg::t_res o_res,
    input  logic          i_res_stall
);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [TABLE_DEPTH-1:0] r_valid;
    tft_pkg::t_key r_key   [TABLE_DEPTH];
    logic [47:0]   r_first [TABLE_DEPTH];
    logic [47:0]   r_lastt [TABLE_DEPTH];
    logic [1:0]    r_fst   [TABLE_DEPTH];
    logic [CW-1:0] r_count;
    logic [5:0]    r_max_flows;
    logic [31:0]   r_grace;
    tft_pkg::t_cmd r_cmd;
    logic [IW-1:0] r_idx;
    logic [TABLE_DEPTH-1:0] r_hitv;
    tft_pkg::t_res r_res;
    logic          r_res_valid;

    // parallel key compare, registered
    logic [TABLE_DEPTH-1:0] hitv;
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hitv[i] = r_valid[i] && (r_key[i] == i_cmd.key);
        end
    end

    // hit and free encoders
    logic          hit, has_free;
    logic [IW-1:0] hit_idx, free_idx;
    always_comb begin
        hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (r_hitv[i]) begin
                hit = 1'b1; hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                has_free = 1'b1; free_idx = IW'(i);
            end
        end
    end

    // flow limit
    logic [CW-1:0] limit;
    always_comb begin
        if (r_max_flows == 6'd0 || {26'd0, r_max_flows} > 32'(TABLE_DEPTH)) begin
            limit = CW'(TABLE_DEPTH);
        end else begin
            limit = CW'(r_max_flows);
        end
    end

    logic out_free;
    logic do_exec;
    assign out_free   = !r_res_valid || !i_res_stall;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign do_exec    = (r_state == S_EXEC) && out_free && (r_cmd.op != tft_pkg::OP_SCAN);

    // packet execution values
    logic [1:0]    st0, st1;
    logic [47:0]   fs0, elapsed;
    always_comb begin
        st0  = hit ? r_fst[hit_idx]
                   : (r_cmd.is_syn ? tft_pkg::FS_ACTIVE_SYN : tft_pkg::FS_PENDING_DATA);
        fs0  = hit ? r_first[hit_idx] : r_cmd.timestamp;
        elapsed = r_cmd.timestamp - fs0;
        st1 = st0;
        if (r_cmd.is_syn) begin
            st1 = tft_pkg::FS_ACTIVE_SYN;
        end else if (r_cmd.has_data) begin
            if (st0 == tft_pkg::FS_PENDING_DATA) begin
                if (r_cmd.timestamp >= fs0 && elapsed >= {16'd0, r_grace}) begin
                    st1 = tft_pkg::FS_ACTIVE_DATA;
                end
            end else if (st0 == tft_pkg::FS_ACTIVE_SYN) begin
                st1 = tft_pkg::FS_ACTIVE_DATA;
            end
        end
    end

    // scan compare on current entry
    logic [47:0] idle_t;
    logic        is_idle;
    assign idle_t  = r_cmd.timestamp - r_lastt[r_idx];
    assign is_idle = r_valid[r_idx] && (r_cmd.idle_timeout != 32'd0)
                   && (r_cmd.timestamp > r_lastt[r_idx])
                   && (idle_t > {16'd0, r_cmd.idle_timeout});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd.op == tft_pkg::OP_SCAN) n_state = S_SCAN;
                else if (out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (out_free && r_idx == IW'(TABLE_DEPTH - 1)) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        // command capture
        if (o_cmd_take) begin
            r_cmd  <= i_cmd;
            r_hitv <= hitv;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_max_flows <= '0;
            r_grace     <= '0;
            r_res_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            // configuration writes
            if (i_cfg_we && i_cfg_idx == tft_pkg::CFG_MAX_FLOWS) r_max_flows <= i_cfg_data[5:0];
            if (i_cfg_we && i_cfg_idx == tft_pkg::CFG_GRACE_TICKS) r_grace <= i_cfg_data;
            if (r_res_valid && !i_res_stall) r_res_valid <= 1'b0;
            if (o_cmd_take) r_idx <= '0;
            // execute packet, complete or touch
            if (do_exec) begin
                r_res_valid      <= 1'b1;
                r_res.key        <= r_cmd.key;
                r_res.flow_state <= 2'd0;
                r_res.last       <= 1'b1;
                case (r_cmd.op)
                    tft_pkg::OP_PACKET: begin
                        if (hit) begin
                            r_res.status     <= tft_pkg::ST_TRACKED;
                            r_res.flow_state <= st1;
                            r_lastt[hit_idx] <= r_cmd.timestamp;
                            r_fst[hit_idx]   <= st1;
                        end else if (r_count >= limit || !has_free) begin
                            r_res.status <= tft_pkg::ST_FULL;
                        end else if (!r_cmd.is_syn && !r_cmd.has_data) begin
                            r_res.status <= tft_pkg::ST_IGNORED;
                        end else begin
                            r_res.status      <= tft_pkg::ST_NEW;
                            r_res.flow_state  <= st1;
                            r_valid[free_idx] <= 1'b1;
                            r_count           <= r_count + CW'(1);
                            r_key[free_idx]   <= r_cmd.key;
                            r_first[free_idx] <= r_cmd.timestamp;
                            r_lastt[free_idx] <= r_cmd.timestamp;
                            r_fst[free_idx]   <= st1;
                        end
                    end
                    tft_pkg::OP_COMPLETE: begin
                        if (!hit) begin
                            r_res.status <= tft_pkg::ST_NOT_FOUND;
                        end else begin
                            r_res.status     <= tft_pkg::ST_COMPLETED;
                            r_res.flow_state <= r_fst[hit_idx];
                            r_valid[hit_idx] <= 1'b0;
                            r_count          <= r_count - CW'(1);
                        end
                    end
                    tft_pkg::OP_TOUCH: begin
                        if (!hit) begin
                            r_res.status <= tft_pkg::ST_NOT_FOUND;
                        end else begin
                            r_res.status     <= tft_pkg::ST_TOUCHED;
                            r_res.flow_state <= r_fst[hit_idx];
                            r_lastt[hit_idx] <= r_cmd.timestamp;
                        end
                    end
                    default: begin
                        // scan is walked in its own states
                    end
                endcase
            end
            // idle scan walk, one entry per cycle while the output is not stalled
            if (r_state == S_SCAN && out_free) begin
                r_res_valid      <= is_idle;
                r_res.status     <= tft_pkg::ST_IDLE;
                r_res.key        <= r_key[r_idx];
                r_res.flow_state <= r_fst[r_idx];
                r_res.last       <= 1'b0;
                if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            // closing marker of the scan
            if (r_state == S_DONE && out_free) begin
                r_res_valid      <= 1'b1;
                r_res.status     <= tft_pkg::ST_SCAN_DONE;
                r_res.key        <= '0;
                r_res.flow_state <= 2'd0;
                r_res.last       <= 1'b1;
            end
        end
    end
endmodule

@@ design/tcp_flow_tracking_table.sv @@
// top level of the tcp flow tracking table
// Flow table of TABLE_DEPTH entries keyed by the IPv4 5-tuple. A two-entry command
// queue decouples input from execution. Packet, complete and touch each pass a queue
// pop with a registered parallel key compare, then an execute step. An idle scan
// runs through the pop, a dispatch step, a walk over the entries in order, and the
// closing marker. A stalled output holds execution back; the command queue still
// takes up to two beats while a result waits.
module tcp_flow_tracking_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_protocol,
    input  logic        i_is_syn,
    input  logic [15:0] i_payload_len,
    input  logic [47:0] i_timestamp,
    input  logic [31:0] i_idle_timeout,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [31:0] o_out_src_addr,
    output logic [31:0] o_out_dst_addr,
    output logic [15:0] o_out_src_port,
    output logic [15:0] o_out_dst_port,
    output logic [7:0]  o_out_protocol,
    output logic [1:0]  o_flow_state,
    output logic        o_last
);
    logic          cmd_valid, cmd_take;
    tft_pkg::t_cmd cmd;
    tft_pkg::t_res res;

    tft_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_src_addr, .i_dst_addr,
        .i_src_port, .i_dst_port, .i_protocol, .i_is_syn, .i_payload_len,
        .i_timestamp, .i_idle_timeout,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    tft_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_res_valid(o_valid), .o_res(res), .i_res_stall(i_stall)
    );

    assign o_status       = res.status;
    assign o_out_src_addr = res.key.src_addr;
    assign o_out_dst_addr = res.key.dst_addr;
    assign o_out_src_port = res.key.src_port;
    assign o_out_dst_port = res.key.dst_port;
    assign o_out_protocol = res.key.protocol;
    assign o_flow_state   = res.flow_state;
    assign o_last         = res.last;
endmodule

@@ design/tft_checker.sv @@
// port-level checks of the flow tracking table
`include "tcp_flow_tracking_table_macros.svh"
module tft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_status,
    input logic [1:0] o_flow_state,
    input logic       o_last
);
    `FT_ASSERT(a_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status), "stalled beat changed")
    `FT_ASSERT(a_idle_not_last, i_clk, i_rst_n, o_valid && o_status == tft_pkg::ST_IDLE |-> !o_last, "idle flow marked last")
    `FT_ASSERT(a_done_last, i_clk, i_rst_n, o_valid && o_status != tft_pkg::ST_IDLE |-> o_last, "final beat not marked last")
    `FT_ASSERT(a_state_range, i_clk, i_rst_n, o_valid |-> o_flow_state != 2'd3, "bad flow state")
endmodule

bind tcp_flow_tracking_table tft_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_status, .o_flow_state, .o_last
);
